>>> rtl/tbb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbb_pkg
// Shared types and constants of the transformed bounding box block.
// ----------------------------------------------------------------------------
package tbb_pkg;

    // Coordinate, coefficient and register widths.
    localparam int TBB_COORD_W  = 32;
    localparam int TBB_COEF_W   = 16;
    localparam int TBB_ROW_W    = 3 * TBB_COEF_W;
    localparam int TBB_CFG_W    = TBB_ROW_W;
    localparam int TBB_CFG_IDX_W = 3;

    // Default number of fraction bits of the matrix coefficients.
    localparam int TBB_COEF_FRAC_BITS = 12;

    typedef logic signed [TBB_COORD_W-1:0] coord_t;
    typedef logic signed [TBB_COEF_W-1:0]  coef_t;
    typedef logic        [TBB_ROW_W-1:0]   row_t;

    localparam coord_t TBB_COORD_MAX = {1'b0, {(TBB_COORD_W-1){1'b1}}};
    localparam coord_t TBB_COORD_MIN = {1'b1, {(TBB_COORD_W-1){1'b0}}};

    // Identity matrix in Q4.12.
    localparam row_t TBB_ROW_X_RESET = row_t'(48'h0000_0000_1000);
    localparam row_t TBB_ROW_Y_RESET = row_t'(48'h0000_1000_0000);
    localparam row_t TBB_ROW_Z_RESET = row_t'(48'h1000_0000_0000);

    // Configuration register indexes.
    typedef enum logic [TBB_CFG_IDX_W-1:0] {
        CFG_ROW_X    = 3'd0,
        CFG_ROW_Y    = 3'd1,
        CFG_ROW_Z    = 3'd2,
        CFG_OFFSET_X = 3'd3,
        CFG_OFFSET_Y = 3'd4,
        CFG_OFFSET_Z = 3'd5
    } cfg_reg_e;

    // Load enables of the two transform stages.
    typedef struct packed {
        logic prod_en;
        logic sum_en;
    } tbb_ctl_t;

endpackage : tbb_pkg
`default_nettype wire

>>> rtl/tbb_xform.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbb_xform
// One row of the affine transform: three products, then sum, floor shift,
// offset and saturation to the coordinate range. Two register stages.
// ----------------------------------------------------------------------------
module tbb_xform
    import tbb_pkg::*;
#(
    parameter int COEF_FRAC_BITS = TBB_COEF_FRAC_BITS
)
(
    input  wire logic     clk,
    input  wire tbb_ctl_t ctl,
    input  wire row_t     row,
    input  wire coord_t   offset,
    input  wire coord_t   x,
    input  wire coord_t   y,
    input  wire coord_t   z,
    output coord_t        result
);

    localparam int PROD_W = TBB_COEF_W + TBB_COORD_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int ACC_W  = SUM_W + 1;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    coef_t  coef_a;
    coef_t  coef_b;
    coef_t  coef_c;
    prod_t  prod_a_reg;
    prod_t  prod_b_reg;
    prod_t  prod_c_reg;
    sum_t   sum;
    sum_t   sum_shifted;
    acc_t   acc;
    logic   acc_fits;
    coord_t result_next;
    coord_t result_reg;

    assign coef_a = coef_t'(row[TBB_COEF_W-1:0]);
    assign coef_b = coef_t'(row[2*TBB_COEF_W-1:TBB_COEF_W]);
    assign coef_c = coef_t'(row[3*TBB_COEF_W-1:2*TBB_COEF_W]);

    always_ff @(posedge clk)
    begin
        if (ctl.prod_en)
        begin
            prod_a_reg <= prod_t'(coef_a) * prod_t'(x);
            prod_b_reg <= prod_t'(coef_b) * prod_t'(y);
            prod_c_reg <= prod_t'(coef_c) * prod_t'(z);
        end
    end

    // The exact sum is floored by the coefficient scale before the offset.
    always_comb
    begin
        sum         = sum_t'(prod_a_reg) + sum_t'(prod_b_reg) + sum_t'(prod_c_reg);
        sum_shifted = sum >>> COEF_FRAC_BITS;
        acc         = acc_t'(sum_shifted) + acc_t'(offset);
        acc_fits    = (acc[ACC_W-1:TBB_COORD_W-1] ==
                       {(ACC_W-TBB_COORD_W+1){acc[TBB_COORD_W-1]}});
        if (acc_fits)
        begin
            result_next = coord_t'(acc[TBB_COORD_W-1:0]);
        end
        else if (acc[ACC_W-1])
        begin
            result_next = TBB_COORD_MIN;
        end
        else
        begin
            result_next = TBB_COORD_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum_en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule : tbb_xform
`default_nettype wire

>>> rtl/transformed_bounding_box.sv
`default_nettype none
// ----------------------------------------------------------------------------
// transformed_bounding_box
// Affine transform of a vertex stream with per-set axis-aligned bounding box.
// ----------------------------------------------------------------------------
// The block takes one vertex per clock cycle unless stalled and keeps running
// up. Each vertex is multiplied by the configured matrix (three Q4.12 rows
// plus Q16.16 offsets), saturated to 32 bits, and folded into running
// per-axis minima and maxima. The vertex flagged with last_vertex closes the
// set: the box of all vertices of the set, including the flagged one, and its
// center min + ((max - min) >>> 1) are presented as one output item, and the
// running extremes start over. The pipeline is input register, product
// register, transform register, tracking stage with a box register, and the
// output register. The sustained rate is one vertex per cycle, set by the min
// and max compare per axis in the tracking stage. A stalled output only holds
// back the stream when a set-closing vertex meets a full box register.
// Configuration registers are written through a simple write port; the user
// must write them only while the block is idle; this is not enforced.
// ----------------------------------------------------------------------------
module transformed_bounding_box
    import tbb_pkg::*;
#(
    parameter int COEF_FRAC_BITS = TBB_COEF_FRAC_BITS
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     cfg_write,
    input  wire logic [TBB_CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TBB_CFG_W-1:0]     cfg_data,

    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire coord_t                   vert_x,
    input  wire coord_t                   vert_y,
    input  wire coord_t                   vert_z,
    input  wire logic                     last_vertex,

    output logic                          out_valid,
    input  wire logic                     out_stall,
    output coord_t                        box_min_x,
    output coord_t                        box_max_x,
    output coord_t                        box_min_y,
    output coord_t                        box_max_y,
    output coord_t                        box_min_z,
    output coord_t                        box_max_z,
    output coord_t                        center_x,
    output coord_t                        center_y,
    output coord_t                        center_z
);

    // ------------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------------
    row_t   row_x_reg;
    row_t   row_y_reg;
    row_t   row_z_reg;
    coord_t offset_x_reg;
    coord_t offset_y_reg;
    coord_t offset_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg    <= TBB_ROW_X_RESET;
            row_y_reg    <= TBB_ROW_Y_RESET;
            row_z_reg    <= TBB_ROW_Z_RESET;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
        end
        else if (cfg_write)
        begin
            // Writes to an index past the register list are dropped.
            case (cfg_reg_e'(cfg_index))
                CFG_ROW_X:    row_x_reg    <= cfg_data;
                CFG_ROW_Y:    row_y_reg    <= cfg_data;
                CFG_ROW_Z:    row_z_reg    <= cfg_data;
                CFG_OFFSET_X: offset_x_reg <= coord_t'(cfg_data[TBB_COORD_W-1:0]);
                CFG_OFFSET_Y: offset_y_reg <= coord_t'(cfg_data[TBB_COORD_W-1:0]);
                CFG_OFFSET_Z: offset_z_reg <= coord_t'(cfg_data[TBB_COORD_W-1:0]);
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline flow control. Every stage moves on as soon as the stage after
    // it is empty or moving itself. Only a set-closing item needs room in the
    // box stage; all other items are absorbed by the tracking stage.
    // ------------------------------------------------------------------------
    logic     in_valid_reg;
    logic     prod_valid_reg;
    logic     xf_valid_reg;
    logic     box_valid_reg;
    logic     out_valid_reg;
    logic     last_in_reg;
    logic     last_prod_reg;
    logic     last_xf_reg;

    logic     out_ready;
    logic     box_ready;
    logic     xf_leave;
    logic     xf_ready;
    logic     prod_ready;
    logic     in_ready;
    logic     in_accept;
    tbb_ctl_t xf_ctl;

    assign out_ready  = !out_valid_reg || !out_stall;
    assign box_ready  = !box_valid_reg || out_ready;
    assign xf_leave   = xf_valid_reg && (!last_xf_reg || box_ready);
    assign xf_ready   = !xf_valid_reg || xf_leave;
    assign prod_ready = !prod_valid_reg || xf_ready;
    assign in_ready   = !in_valid_reg || prod_ready;
    assign in_accept  = in_valid && in_ready;
    assign in_stall   = !in_ready;

    assign xf_ctl.prod_en = in_valid_reg && prod_ready;
    assign xf_ctl.sum_en  = prod_valid_reg && xf_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            xf_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (prod_ready)
            begin
                prod_valid_reg <= in_valid_reg;
            end
            if (xf_ready)
            begin
                xf_valid_reg <= prod_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input register and the set-closing flag that travels with each item.
    // ------------------------------------------------------------------------
    coord_t vx_reg;
    coord_t vy_reg;
    coord_t vz_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            vx_reg      <= vert_x;
            vy_reg      <= vert_y;
            vz_reg      <= vert_z;
            last_in_reg <= last_vertex;
        end
        if (xf_ctl.prod_en)
        begin
            last_prod_reg <= last_in_reg;
        end
        if (xf_ctl.sum_en)
        begin
            last_xf_reg <= last_prod_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Transform: one unit per output axis.
    // ------------------------------------------------------------------------
    coord_t tx;
    coord_t ty;
    coord_t tz;

    tbb_xform #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_xform_x
    (
        .clk    (clk),
        .ctl    (xf_ctl),
        .row    (row_x_reg),
        .offset (offset_x_reg),
        .x      (vx_reg),
        .y      (vy_reg),
        .z      (vz_reg),
        .result (tx)
    );

    tbb_xform #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_xform_y
    (
        .clk    (clk),
        .ctl    (xf_ctl),
        .row    (row_y_reg),
        .offset (offset_y_reg),
        .x      (vx_reg),
        .y      (vy_reg),
        .z      (vz_reg),
        .result (ty)
    );

    tbb_xform #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_xform_z
    (
        .clk    (clk),
        .ctl    (xf_ctl),
        .row    (row_z_reg),
        .offset (offset_z_reg),
        .x      (vx_reg),
        .y      (vy_reg),
        .z      (vz_reg),
        .result (tz)
    );

    // ------------------------------------------------------------------------
    // Running extremes. The closing vertex is folded in first; the finished
    // box moves to the box register and the extremes start over.
    // ------------------------------------------------------------------------
    coord_t run_min_x_reg;
    coord_t run_max_x_reg;
    coord_t run_min_y_reg;
    coord_t run_max_y_reg;
    coord_t run_min_z_reg;
    coord_t run_max_z_reg;
    coord_t run_min_x_next;
    coord_t run_max_x_next;
    coord_t run_min_y_next;
    coord_t run_max_y_next;
    coord_t run_min_z_next;
    coord_t run_max_z_next;

    always_comb
    begin
        run_min_x_next = (tx <= run_min_x_reg) ? tx : run_min_x_reg;
        run_max_x_next = (tx >= run_max_x_reg) ? tx : run_max_x_reg;
        run_min_y_next = (ty <= run_min_y_reg) ? ty : run_min_y_reg;
        run_max_y_next = (ty >= run_max_y_reg) ? ty : run_max_y_reg;
        run_min_z_next = (tz <= run_min_z_reg) ? tz : run_min_z_reg;
        run_max_z_next = (tz >= run_max_z_reg) ? tz : run_max_z_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_min_x_reg <= TBB_COORD_MAX;
            run_max_x_reg <= TBB_COORD_MIN;
            run_min_y_reg <= TBB_COORD_MAX;
            run_max_y_reg <= TBB_COORD_MIN;
            run_min_z_reg <= TBB_COORD_MAX;
            run_max_z_reg <= TBB_COORD_MIN;
        end
        else if (xf_leave)
        begin
            if (last_xf_reg)
            begin
                run_min_x_reg <= TBB_COORD_MAX;
                run_max_x_reg <= TBB_COORD_MIN;
                run_min_y_reg <= TBB_COORD_MAX;
                run_max_y_reg <= TBB_COORD_MIN;
                run_min_z_reg <= TBB_COORD_MAX;
                run_max_z_reg <= TBB_COORD_MIN;
            end
            else
            begin
                run_min_x_reg <= run_min_x_next;
                run_max_x_reg <= run_max_x_next;
                run_min_y_reg <= run_min_y_next;
                run_max_y_reg <= run_max_y_next;
                run_min_z_reg <= run_min_z_next;
                run_max_z_reg <= run_max_z_next;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Box register: holds a finished box while its center is formed.
    // ------------------------------------------------------------------------
    logic   box_load;
    coord_t bmin_x_reg;
    coord_t bmax_x_reg;
    coord_t bmin_y_reg;
    coord_t bmax_y_reg;
    coord_t bmin_z_reg;
    coord_t bmax_z_reg;

    assign box_load = xf_leave && last_xf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_valid_reg <= 1'b0;
        end
        else if (box_ready)
        begin
            box_valid_reg <= box_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (box_load)
        begin
            bmin_x_reg <= run_min_x_next;
            bmax_x_reg <= run_max_x_next;
            bmin_y_reg <= run_min_y_next;
            bmax_y_reg <= run_max_y_next;
            bmin_z_reg <= run_min_z_next;
            bmax_z_reg <= run_max_z_next;
        end
    end

    // ------------------------------------------------------------------------
    // Center: the extent is formed in 33 bits so it cannot wrap, halved with
    // an arithmetic shift (toward minus infinity) and added to the minimum.
    // ------------------------------------------------------------------------
    localparam int EXT_W = TBB_COORD_W + 1;
    typedef logic signed [EXT_W-1:0] ext_t;

    logic   out_load;
    ext_t   ext_x;
    ext_t   ext_y;
    ext_t   ext_z;
    ext_t   mid_x;
    ext_t   mid_y;
    ext_t   mid_z;

    always_comb
    begin
        ext_x = ext_t'(bmax_x_reg) - ext_t'(bmin_x_reg);
        ext_y = ext_t'(bmax_y_reg) - ext_t'(bmin_y_reg);
        ext_z = ext_t'(bmax_z_reg) - ext_t'(bmin_z_reg);
        mid_x = ext_t'(bmin_x_reg) + (ext_x >>> 1);
        mid_y = ext_t'(bmin_y_reg) + (ext_y >>> 1);
        mid_z = ext_t'(bmin_z_reg) + (ext_z >>> 1);
    end

    // ------------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------------
    coord_t omin_x_reg;
    coord_t omax_x_reg;
    coord_t omin_y_reg;
    coord_t omax_y_reg;
    coord_t omin_z_reg;
    coord_t omax_z_reg;
    coord_t ocen_x_reg;
    coord_t ocen_y_reg;
    coord_t ocen_z_reg;

    assign out_load = box_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= box_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            omin_x_reg <= bmin_x_reg;
            omax_x_reg <= bmax_x_reg;
            omin_y_reg <= bmin_y_reg;
            omax_y_reg <= bmax_y_reg;
            omin_z_reg <= bmin_z_reg;
            omax_z_reg <= bmax_z_reg;
            ocen_x_reg <= coord_t'(mid_x[TBB_COORD_W-1:0]);
            ocen_y_reg <= coord_t'(mid_y[TBB_COORD_W-1:0]);
            ocen_z_reg <= coord_t'(mid_z[TBB_COORD_W-1:0]);
        end
    end

    assign out_valid = out_valid_reg;
    assign box_min_x = omin_x_reg;
    assign box_max_x = omax_x_reg;
    assign box_min_y = omin_y_reg;
    assign box_max_y = omax_y_reg;
    assign box_min_z = omin_z_reg;
    assign box_max_z = omax_z_reg;
    assign center_x  = ocen_x_reg;
    assign center_y  = ocen_y_reg;
    assign center_z  = ocen_z_reg;

endmodule : transformed_bounding_box
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the transformed bounding box block.
// ----------------------------------------------------------------------------
// Vertices are pushed through the valid/stall input channel while a local
// predictor applies the same affine transform, saturation and running min/max
// tracking. Every vertex flagged last pushes one predicted box onto a queue,
// and the output process compares each box the block hands over, field by
// field, against the oldest prediction. Directed items cover the reset
// matrix, saturation at both ends, floor rounding, odd-span centers and the
// unused register indexes. Random sets follow under several matrices, with
// random gaps on both channels, a long output hold and a sender pause.
// ----------------------------------------------------------------------------
module tb_top
    import tbb_pkg::*;
();

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_WAIT      = 6;

    // The index field is three bits wide but only six registers exist. The
    // two spare codes must leave every register untouched.
    localparam logic [TBB_CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [TBB_CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        coord_t min_x;
        coord_t max_x;
        coord_t min_y;
        coord_t max_y;
        coord_t min_z;
        coord_t max_z;
        coord_t center_x;
        coord_t center_y;
        coord_t center_z;
    } box_t;

    // Every input starts at a known value.
    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     cfg_write   = 1'b0;
    logic [TBB_CFG_IDX_W-1:0] cfg_index   = '0;
    logic [TBB_CFG_W-1:0]     cfg_data    = '0;
    logic                     in_valid    = 1'b0;
    logic                     in_stall;
    coord_t                   vert_x      = '0;
    coord_t                   vert_y      = '0;
    coord_t                   vert_z      = '0;
    logic                     last_vertex = 1'b0;
    logic                     out_valid;
    logic                     out_stall   = 1'b0;
    coord_t                   box_min_x;
    coord_t                   box_max_x;
    coord_t                   box_min_y;
    coord_t                   box_max_y;
    coord_t                   box_min_z;
    coord_t                   box_max_z;
    coord_t                   center_x;
    coord_t                   center_y;
    coord_t                   center_z;

    // Predictor state: the matrix as last written and the running extremes,
    // indexed by axis (0 = x, 1 = y, 2 = z).
    row_t   model_row [3];
    coord_t model_off [3];
    coord_t run_min   [3];
    coord_t run_max   [3];

    box_t   pending_boxes [$];

    // Knobs shared between the stimulus and the output process.
    bit     tx_idle_en   = 1'b0;
    bit     rx_idle_en   = 1'b0;
    logic   hold_go      = 1'b0;
    int     rx_wait_left = 0;
    int     rx_hold_left = 0;

    int     mismatches    = 0;
    int     boxes_checked = 0;
    int     vertices_sent = 0;
    int     cfg_writes    = 0;
    int     cycle_count   = 0;

    transformed_bounding_box i_dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // One output axis: exact 64-bit dot product, floor shift by the
    // coefficient fraction, translation, then clamp to 32 bits.
    function automatic coord_t transform_axis(row_t row, coord_t off,
                                              coord_t x, coord_t y, coord_t z);
        longint acc;
        acc = longint'($signed(row[15:0]))  * longint'(x)
            + longint'($signed(row[31:16])) * longint'(y)
            + longint'($signed(row[47:32])) * longint'(z);
        acc = (acc >>> TBB_COEF_FRAC_BITS) + longint'(off);
        if (acc > longint'(TBB_COORD_MAX))
            return TBB_COORD_MAX;
        if (acc < longint'(TBB_COORD_MIN))
            return TBB_COORD_MIN;
        return coord_t'(acc);
    endfunction

    // The span is taken in full width, so halving it rounds toward minus
    // infinity and the sum always fits back into 32 bits.
    function automatic coord_t box_center(coord_t lo, coord_t hi);
        longint span;
        span = longint'(hi) - longint'(lo);
        return coord_t'(longint'(lo) + (span >>> 1));
    endfunction

    function automatic void clear_extremes();
        for (int a = 0; a < 3; a++)
        begin
            run_min[a] = TBB_COORD_MAX;
            run_max[a] = TBB_COORD_MIN;
        end
    endfunction

    // Folds an accepted vertex into the extremes; a vertex flagged last also
    // closes the set and queues the box the block owes us.
    function automatic void fold_vertex(coord_t x, coord_t y, coord_t z, logic last);
        coord_t v;
        box_t   box;
        for (int a = 0; a < 3; a++)
        begin
            v = transform_axis(model_row[a], model_off[a], x, y, z);
            if (v <= run_min[a])
                run_min[a] = v;
            if (v >= run_max[a])
                run_max[a] = v;
        end
        if (last)
        begin
            box.min_x    = run_min[0];
            box.max_x    = run_max[0];
            box.min_y    = run_min[1];
            box.max_y    = run_max[1];
            box.min_z    = run_min[2];
            box.max_z    = run_max[2];
            box.center_x = box_center(run_min[0], run_max[0]);
            box.center_y = box_center(run_min[1], run_max[1]);
            box.center_z = box_center(run_min[2], run_max[2]);
            pending_boxes.push_back(box);
            clear_extremes();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Random value sources
    // ------------------------------------------------------------------------

    // Coordinates: the two extremes, values near zero so that sets do not
    // all collapse onto the clamp, and plain 32-bit noise.
    function automatic coord_t pick_coord();
        case ($urandom_range(0, 7))
            0:       return TBB_COORD_MAX;
            1:       return TBB_COORD_MIN;
            2, 3:    return coord_t'($urandom_range(0, 20'hF_FFFF)) - coord_t'(32'h0008_0000);
            default: return coord_t'($urandom());
        endcase
    endfunction

    function automatic coef_t pick_coef();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return coef_t'(16'h1000);
            2:       return $urandom_range(0, 1) ? coef_t'(16'h7FFF) : coef_t'(16'h8000);
            3, 4:    return coef_t'($urandom_range(0, 16'h3FFF)) - coef_t'(16'h2000);
            default: return coef_t'($urandom());
        endcase
    endfunction

    function automatic row_t pick_row();
        return {pick_coef(), pick_coef(), pick_coef()};
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Presents one vertex and returns at the edge that accepts it. A gap of
    // idle cycles may come first; valid is only lowered when a gap is drawn,
    // so back-to-back items keep it high without a second assignment.
    task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z,
                               input logic last);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        vert_x      <= x;
        vert_y      <= y;
        vert_z      <= z;
        last_vertex <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        fold_vertex(x, y, z, last);
        vertices_sent++;
    endtask

    // Stops the input stream, waits for every owed box, then lets the
    // pipeline empty out any trailing vertices that produce no box.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_boxes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves the write enable high so that a burst of writes never lowers
    // and raises it within one time step; the caller drops it afterwards.
    task automatic write_reg(input logic [TBB_CFG_IDX_W-1:0] idx,
                             input logic [TBB_CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_ROW_X:    model_row[0] = data;
            CFG_ROW_Y:    model_row[1] = data;
            CFG_ROW_Z:    model_row[2] = data;
            CFG_OFFSET_X: model_off[0] = coord_t'(data[31:0]);
            CFG_OFFSET_Y: model_off[1] = coord_t'(data[31:0]);
            CFG_OFFSET_Z: model_off[2] = coord_t'(data[31:0]);
            default:      ;
        endcase
        cfg_writes++;
    endtask

    // Loads a whole matrix once the block is idle. Offsets carry random
    // upper bits, which the block must drop.
    task automatic program_transform(input row_t rx, input row_t ry, input row_t rz,
                                     input coord_t ox, input coord_t oy, input coord_t oz);
        wait_idle();
        write_reg(CFG_ROW_X, rx);
        write_reg(CFG_ROW_Y, ry);
        write_reg(CFG_ROW_Z, rz);
        write_reg(CFG_OFFSET_X, {16'($urandom()), ox});
        write_reg(CFG_OFFSET_Y, {16'($urandom()), oy});
        write_reg(CFG_OFFSET_Z, {16'($urandom()), oz});
        cfg_write <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Output side: stall pattern and checking
    // ------------------------------------------------------------------------

    function automatic void check_field(string name, coord_t want, coord_t got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Each accepted box is compared with the oldest prediction. After it, a
    // fresh random stall is drawn for the next one. A pulse on hold_go starts
    // a long hold that this process counts down on its own.
    always @(posedge clk or negedge rst_n)
    begin
        box_t want;
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            rx_wait_left = 0;
            rx_hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_boxes.size() == 0)
                begin
                    $error("box delivered while no closed set was outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_boxes.pop_front();
                    check_field("box_min_x", want.min_x, box_min_x);
                    check_field("box_max_x", want.max_x, box_max_x);
                    check_field("box_min_y", want.min_y, box_min_y);
                    check_field("box_max_y", want.max_y, box_max_y);
                    check_field("box_min_z", want.min_z, box_min_z);
                    check_field("box_max_z", want.max_z, box_max_z);
                    check_field("center_x", want.center_x, center_x);
                    check_field("center_y", want.center_y, center_y);
                    check_field("center_z", want.center_z, center_z);
                    boxes_checked++;
                end
                rx_wait_left = rx_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if (hold_go)
                rx_hold_left = LONG_HOLD;
            if (rx_hold_left > 0)
            begin
                out_stall <= 1'b1;
                rx_hold_left--;
            end
            else if (rx_wait_left > 0)
            begin
                out_stall <= 1'b1;
                rx_wait_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles, %0d boxes still owed",
                     cycle_count, pending_boxes.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Identity matrix straight out of reset: a one-vertex set, then a set
    // spanning the full y and z range with an odd negative x span, so the
    // centers show both the full-range case and rounding toward minus
    // infinity.
    task automatic test_reset_matrix();
        send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b1);
        send_vertex(-32'sd3, TBB_COORD_MAX, TBB_COORD_MIN, 1'b0);
        send_vertex(32'sd0, TBB_COORD_MIN, TBB_COORD_MAX, 1'b0);
        send_vertex(-32'sd1, 32'sd1, -32'sd1, 1'b1);
        send_vertex(32'sh1234_5678, -32'sh0765_4321, 32'sh0000_FFFF, 1'b1);
    endtask

    // Largest coefficients with the top offset clamp x high and low, the most
    // negative coefficients with the bottom offset do the same for y, and
    // the smallest coefficient on z shows the floor of a tiny negative sum.
    task automatic test_saturation();
        program_transform(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h0001_0001_0001,
                          TBB_COORD_MAX, TBB_COORD_MIN, 32'sd0);
        send_vertex(TBB_COORD_MAX, TBB_COORD_MAX, TBB_COORD_MAX, 1'b0);
        send_vertex(TBB_COORD_MIN, TBB_COORD_MIN, TBB_COORD_MIN, 1'b0);
        send_vertex(-32'sd1, -32'sd1, -32'sd1, 1'b1);
        send_vertex(-32'sd1, -32'sd1, -32'sd1, 1'b1);
    endtask

    // Writes to the two unused indexes must not disturb the matrix.
    task automatic test_spare_index();
        wait_idle();
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, {16'($urandom()), 32'($urandom())});
        cfg_write <= 1'b0;
        send_vertex(32'sd1, 32'sd2, 32'sd3, 1'b0);
        send_vertex(TBB_COORD_MAX, TBB_COORD_MIN, 32'sd0, 1'b1);
        send_vertex(32'sh0001_0000, -32'sh0001_0000, 32'sh7FFF_0000, 1'b1);
    endtask

    // Bulk of the run: four matrices, each with its own mix of gaps and set
    // lengths. Sets may straddle a matrix change, since the extremes persist.
    task automatic test_random_sets();
        int set_odds;
        for (int phase = 0; phase < 4; phase++)
        begin
            program_transform(pick_row(), pick_row(), pick_row(),
                              pick_coord(), pick_coord(), pick_coord());
            tx_idle_en = (phase == 0) || (phase == 2);
            rx_idle_en <= (phase == 0) || (phase == 3);
            set_odds   = (phase == 1) ? 10 : 3;
            for (int n = 0; n < 75; n++)
                send_vertex(pick_coord(), pick_coord(), pick_coord(),
                            $urandom_range(0, set_odds) == 0);
        end
    endtask

    // The output side holds off for a long stretch while the input keeps
    // offering short sets, so boxes pile up and the block must stall its
    // input.
    task automatic test_output_hold();
        wait_idle();
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
        hold_go    <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        for (int n = 0; n < 60; n++)
            send_vertex(pick_coord(), pick_coord(), pick_coord(), $urandom_range(0, 1));
    endtask

    // The sender stops until every owed box is in, then carries on; the open
    // set, if any, simply continues across the pause.
    task automatic test_sender_pause();
        program_transform(pick_row(), pick_row(), pick_row(),
                          pick_coord(), pick_coord(), pick_coord());
        tx_idle_en = 1'b1;
        rx_idle_en <= 1'b1;
        for (int n = 0; n < 20; n++)
            send_vertex(pick_coord(), pick_coord(), pick_coord(), $urandom_range(0, 3) == 0);
        wait_idle();
        for (int n = 0; n < 20; n++)
            send_vertex(pick_coord(), pick_coord(), pick_coord(),
                        (n == 19) || ($urandom_range(0, 3) == 0));
    endtask

    initial
    begin
        model_row[0] = TBB_ROW_X_RESET;
        model_row[1] = TBB_ROW_Y_RESET;
        model_row[2] = TBB_ROW_Z_RESET;
        for (int a = 0; a < 3; a++)
            model_off[a] = '0;
        clear_extremes();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_matrix();
        test_saturation();
        test_spare_index();
        test_random_sets();
        test_output_hold();
        test_sender_pause();

        wait_idle();
        $display("Checked %0d boxes from %0d vertices across %0d register writes.",
                 boxes_checked, vertices_sent, cfg_writes);
        $display("Covered clamping, spare indexes, random matrices, a long output hold "
                 , "and a sender pause.");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule : tb_top
